// File: hw/rtl/vea_pkg.sv
// Package with the operation codes, widths and transaction types of the vector element ALU.
`timescale 1ns / 1ps

package vea_pkg;

   localparam int MAX_ELEMENTS = 32;
   localparam int LEN_W = $clog2(MAX_ELEMENTS + 1);
   localparam int DATA_W = 32;
   localparam int OP_W = 3;
   localparam int IDX_W = 5;

   typedef enum logic [OP_W-1:0] {
      OP_SET_LEN = 3'd0,
      OP_ADD_VV  = 3'd1,
      OP_ADD_VX  = 3'd2,
      OP_ADD_VI  = 3'd3,
      OP_MUL_VV  = 3'd4,
      OP_RED_SUM = 3'd5
   } op_type;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [IDX_W-1:0]  index;
      logic [DATA_W-1:0] first;
      logic [DATA_W-1:0] second;
      logic [DATA_W-1:0] scalar;
      logic              last;
   } vea_req_type;

   typedef struct packed {
      logic [DATA_W-1:0] element_value;
      logic              element_write;
      logic [DATA_W-1:0] scalar_value;
      logic              scalar_valid;
   } vea_rsp_type;

endpackage

// File: hw/rtl/vea_if.sv
// Valid/ready channel interfaces for the request and response transactions.
`timescale 1ns / 1ps

interface vea_req_if;
   import vea_pkg::*;
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   req_type;
   logic [IDX_W-1:0]  element_index;
   logic [DATA_W-1:0] first_element;
   logic [DATA_W-1:0] second_element;
   logic [DATA_W-1:0] scalar_operand;
   logic              last_element;

   modport source (
      output valid, req_type, element_index, first_element, second_element,
             scalar_operand, last_element,
      input  ready
   );
   modport sink (
      input  valid, req_type, element_index, first_element, second_element,
             scalar_operand, last_element,
      output ready
   );
endinterface

interface vea_rsp_if;
   import vea_pkg::*;
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] element_value;
   logic              element_write;
   logic [DATA_W-1:0] scalar_value;
   logic              scalar_valid;

   modport source (
      output valid, element_value, element_write, scalar_value, scalar_valid,
      input  ready
   );
   modport sink (
      input  valid, element_value, element_write, scalar_value, scalar_valid,
      output ready
   );
endinterface

// File: hw/rtl/vea_execute.sv
// Element datapath with the vector length and running reduction sum registers.
`timescale 1ns / 1ps

module vea_execute
   import vea_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        fire,
   input  vea_req_type req,
   output vea_rsp_type rsp
);

   logic [LEN_W-1:0]  vector_length_ff;
   logic [LEN_W-1:0]  vector_length_in;
   logic [DATA_W-1:0] running_sum_ff;
   logic [DATA_W-1:0] running_sum_in;
   logic              in_range;
   logic [DATA_W-1:0] partial_sum;
   logic [LEN_W-1:0]  new_length;

   assign in_range = {{(LEN_W-IDX_W){1'b0}}, req.index} < vector_length_ff;
   assign partial_sum = in_range ? running_sum_ff + req.first : running_sum_ff;
   assign new_length = (req.scalar < DATA_W'(MAX_ELEMENTS)) ?
                       req.scalar[LEN_W-1:0] : LEN_W'(MAX_ELEMENTS);

   always_comb begin
      rsp = '0;
      vector_length_in = vector_length_ff;
      running_sum_in = running_sum_ff;
      unique case (op_type'(req.op)) inside
         OP_SET_LEN: begin
            vector_length_in = new_length;
            rsp.scalar_value = DATA_W'(new_length);
            rsp.scalar_valid = 1'b1;
         end
         OP_ADD_VV: begin
            rsp.element_value = req.first + req.second;
            rsp.element_write = in_range;
         end
         OP_ADD_VX, OP_ADD_VI: begin
            rsp.element_value = req.first + req.scalar;
            rsp.element_write = in_range;
         end
         OP_MUL_VV: begin
            rsp.element_value = req.first * req.second;
            rsp.element_write = in_range;
         end
         OP_RED_SUM: begin
            if (req.last) begin
               rsp.scalar_value = partial_sum + req.scalar;
               rsp.scalar_valid = 1'b1;
               running_sum_in = '0;
            end else begin
               running_sum_in = partial_sum;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vector_length_ff <= '0;
         running_sum_ff <= '0;
      end else if (fire) begin
         vector_length_ff <= vector_length_in;
         running_sum_ff <= running_sum_in;
      end
   end

endmodule

// File: hw/rtl/vector_element_alu.sv
// Top level of the vector element ALU with its input and result registers.
`timescale 1ns / 1ps

// One element lane of a small vector execute unit. It takes one request
// transaction per cycle while the response side is not stalled, and returns
// exactly one response transaction for each. A request is held in the input
// register, then its result in the result register, with the add,
// the 32-bit multiply and the length and sum updates done in a single pass
// between them. Set length saturates at 32 elements, and a reduction keeps its
// partial sum across transactions until an item marked last returns it.
module vector_element_alu
   import vea_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   vea_req_if.sink  req_chan,
   vea_rsp_if.source rsp_chan
);

   logic        stage_valid_ff;
   logic        stage_valid_in;
   vea_req_type stage_req_ff;
   logic        out_valid_ff;
   logic        out_valid_in;
   vea_rsp_type out_rsp_ff;
   vea_rsp_type exec_rsp;
   logic        out_free;
   logic        advance;
   logic        accept;

   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign advance = stage_valid_ff && out_free;
   assign req_chan.ready = !stage_valid_ff || out_free;
   assign accept = req_chan.valid && req_chan.ready;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (accept) begin
         stage_valid_in = 1'b1;
      end else if (advance) begin
         stage_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_req_ff.op <= req_chan.req_type;
         stage_req_ff.index <= req_chan.element_index;
         stage_req_ff.first <= req_chan.first_element;
         stage_req_ff.second <= req_chan.second_element;
         stage_req_ff.scalar <= req_chan.scalar_operand;
         stage_req_ff.last <= req_chan.last_element;
      end
      if (advance) begin
         out_rsp_ff <= exec_rsp;
      end
   end

   vea_execute u_execute (
      .clock (clock),
      .reset (reset),
      .fire  (advance),
      .req   (stage_req_ff),
      .rsp   (exec_rsp)
   );

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.element_value = out_rsp_ff.element_value;
   assign rsp_chan.element_write = out_rsp_ff.element_write;
   assign rsp_chan.scalar_value = out_rsp_ff.scalar_value;
   assign rsp_chan.scalar_valid = out_rsp_ff.scalar_valid;

endmodule

// File: hw/rtl/vea_checker.sv
// Assertion checker on the response ports of the vector element ALU, with its bind.
`timescale 1ns / 1ps

module vea_checker
   import vea_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic              rsp_element_write,
   input logic [DATA_W-1:0] rsp_scalar_value,
   input logic              rsp_scalar_valid
);

   // A response transaction waiting on a stall stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // Nothing is offered in the cycle after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response offered right after reset");

   // No operation both writes an element and returns a scalar.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_element_write && rsp_scalar_valid))
      else $error("element write and scalar result together");

   // A response without a scalar carries a zero scalar value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_scalar_valid |-> rsp_scalar_value == '0)
      else $error("nonzero scalar value without scalar valid");

endmodule

bind vector_element_alu vea_checker u_vea_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_element_write (rsp_chan.element_write),
   .rsp_scalar_value  (rsp_chan.scalar_value),
   .rsp_scalar_valid  (rsp_chan.scalar_valid)
);
